### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, included by the heater monitor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active-low reset).
`define ASSERT_PROP(lbl, clk_sig, rst_n_sig, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
        else $error("assertion failed");

// Clocked property that holds in and out of reset.
`define ASSERT_ALWAYS(lbl, clk_sig, prop) \
    lbl: assert property (@(posedge clk_sig) prop) \
        else $error("assertion failed");

`endif

### rtl/hsfm_pkg.sv
// ----------------------------------------------------------------------------
// hsfm_pkg
// Types, register indexes, reset values and fault codes of the heater monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package hsfm_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 22;

    typedef logic signed [12:0] temp_t;

    typedef struct packed {
        logic [11:0] rail_low_mv;
        logic [11:0] rail_high_mv;
        temp_t       over_temp_limit;
        logic [15:0] stale_max_ms;
        logic [21:0] window_ms;
        logic [10:0] duty_avg_threshold;
        temp_t       min_rise;
        logic [11:0] setpoint_margin;
    } cfg_t;

    // Register indexes
    localparam logic [CfgIndexWidth-1:0] REG_RAIL_LOW    = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_RAIL_HIGH   = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_OVER_TEMP   = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_STALE_MAX   = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_WINDOW      = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_DUTY_THRESH = 3'd5;
    localparam logic [CfgIndexWidth-1:0] REG_MIN_RISE    = 3'd6;
    localparam logic [CfgIndexWidth-1:0] REG_SP_MARGIN   = 3'd7;

    // Reset values
    localparam logic [11:0] RST_RAIL_LOW    = 12'd100;
    localparam logic [11:0] RST_RAIL_HIGH   = 12'd3200;
    localparam temp_t       RST_OVER_TEMP   = 13'sd2560;
    localparam logic [15:0] RST_STALE_MAX   = 16'd2000;
    localparam logic [21:0] RST_WINDOW      = 22'd60000;
    localparam logic [10:0] RST_DUTY_THRESH = 11'd922;
    localparam temp_t       RST_MIN_RISE    = 13'sd16;
    localparam logic [11:0] RST_SP_MARGIN   = 12'd160;

    // Operations
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Fault codes
    localparam logic [2:0] FAULT_NONE         = 3'd0;
    localparam logic [2:0] FAULT_BOILER_OPEN  = 3'd1;
    localparam logic [2:0] FAULT_BOILER_SHORT = 3'd2;
    localparam logic [2:0] FAULT_GROUP_OPEN   = 3'd3;
    localparam logic [2:0] FAULT_GROUP_SHORT  = 3'd4;
    localparam logic [2:0] FAULT_OVER_TEMP    = 3'd5;
    localparam logic [2:0] FAULT_NO_RISE      = 3'd6;
    localparam logic [2:0] FAULT_STALE        = 3'd7;

endpackage

`default_nettype wire

### rtl/hsfm_cfg_regs.sv
// ----------------------------------------------------------------------------
// hsfm_cfg_regs
// Configuration register file of the heater monitor, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfm_cfg_regs (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  wr_en,
    input  wire logic [hsfm_pkg::CfgIndexWidth-1:0]    wr_index,
    input  wire logic [hsfm_pkg::CfgDataWidth-1:0]     wr_data,
    output hsfm_pkg::cfg_t                             cfg
);

    hsfm_pkg::cfg_t cfg_reg;
    hsfm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                hsfm_pkg::REG_RAIL_LOW:    cfg_next.rail_low_mv        = wr_data[11:0];
                hsfm_pkg::REG_RAIL_HIGH:   cfg_next.rail_high_mv       = wr_data[11:0];
                hsfm_pkg::REG_OVER_TEMP:   cfg_next.over_temp_limit    = wr_data[12:0];
                hsfm_pkg::REG_STALE_MAX:   cfg_next.stale_max_ms       = wr_data[15:0];
                hsfm_pkg::REG_WINDOW:      cfg_next.window_ms          = wr_data[21:0];
                hsfm_pkg::REG_DUTY_THRESH: cfg_next.duty_avg_threshold = wr_data[10:0];
                hsfm_pkg::REG_MIN_RISE:    cfg_next.min_rise           = wr_data[12:0];
                hsfm_pkg::REG_SP_MARGIN:   cfg_next.setpoint_margin    = wr_data[11:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rail_low_mv        <= hsfm_pkg::RST_RAIL_LOW;
            cfg_reg.rail_high_mv       <= hsfm_pkg::RST_RAIL_HIGH;
            cfg_reg.over_temp_limit    <= hsfm_pkg::RST_OVER_TEMP;
            cfg_reg.stale_max_ms       <= hsfm_pkg::RST_STALE_MAX;
            cfg_reg.window_ms          <= hsfm_pkg::RST_WINDOW;
            cfg_reg.duty_avg_threshold <= hsfm_pkg::RST_DUTY_THRESH;
            cfg_reg.min_rise           <= hsfm_pkg::RST_MIN_RISE;
            cfg_reg.setpoint_margin    <= hsfm_pkg::RST_SP_MARGIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/heater_safety_fault_monitor.sv
// ----------------------------------------------------------------------------
// heater_safety_fault_monitor
// Rail, over-temperature, stale and no-rise checks with a latched fault code.
// ----------------------------------------------------------------------------
// Takes one item per clock while out_ready allows and returns one fault_code
// per item, in order. An accepted item is held in the input register along
// with its duty*time and threshold*time products, formed as it is accepted,
// and is resolved into the result register once that register is empty or
// being taken. The update of the latched fault and the window accumulators
// as each item resolves sets the rate. Configuration writes are taken every
// cycle (cfg_ready is held high).
`default_nettype none

module heater_safety_fault_monitor (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [hsfm_pkg::CfgIndexWidth-1:0] cfg_index,
    input  wire logic [hsfm_pkg::CfgDataWidth-1:0]  cfg_data,

    input  wire logic                               in_valid,
    output      logic                               in_ready,
    input  wire logic                               operation,
    input  wire logic [11:0]                        boiler_mv,
    input  wire logic [11:0]                        group_mv,
    input  wire logic signed [12:0]                 boiler_temp,
    input  wire logic signed [12:0]                 boiler_setpoint,
    input  wire logic [15:0]                        reading_age_ms,
    input  wire logic [15:0]                        elapsed_ms,
    input  wire logic [10:0]                        heater_duty,

    output      logic                               out_valid,
    input  wire logic                               out_ready,
    output      logic [2:0]                         fault_code
);

`include "assert_macros.svh"

    hsfm_pkg::cfg_t cfg;

    hsfm_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    logic                  op_reg;
    logic [11:0]           boiler_mv_reg;
    logic [11:0]           group_mv_reg;
    hsfm_pkg::temp_t       temp_reg;
    hsfm_pkg::temp_t       setpoint_reg;
    logic [15:0]           age_reg;
    logic [15:0]           dt_reg;
    logic [26:0]           duty_prod_reg;
    logic [26:0]           thr_prod_reg;

    logic                  out_valid_reg;
    logic [2:0]            fault_code_reg;

    logic                  advance;
    logic                  in_fire;
    logic                  proc;
    logic [26:0]           duty_prod;
    logic [26:0]           thr_prod;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;
    assign proc     = in_valid_reg && advance;

    assign duty_prod = {16'd0, heater_duty} * {11'd0, elapsed_ms};
    assign thr_prod  = {16'd0, cfg.duty_avg_threshold} * {11'd0, elapsed_ms};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg        <= operation;
            boiler_mv_reg <= boiler_mv;
            group_mv_reg  <= group_mv;
            temp_reg      <= boiler_temp;
            setpoint_reg  <= boiler_setpoint;
            age_reg       <= reading_age_ms;
            dt_reg        <= elapsed_ms;
            duty_prod_reg <= duty_prod;
            thr_prod_reg  <= thr_prod;
        end
    end

    // ------------------------------------------------------------------
    // Monitor state
    // ------------------------------------------------------------------
    logic [2:0]            latched_reg,       latched_next;
    logic                  started_reg,       started_next;
    logic [22:0]           elapsed_reg,       elapsed_next;
    logic [33:0]           integral_reg,      integral_next;
    logic [33:0]           thr_time_reg,      thr_time_next;
    hsfm_pkg::temp_t       start_temp_reg,    start_temp_next;
    logic [2:0]            fault_code_next;

    logic [2:0]            check_code;
    logic [22:0]           elapsed_sum;
    logic [33:0]           integral_sum;
    logic [33:0]           thr_sum;
    logic [33:0]           thr_recalc;
    logic                  window_close;
    logic                  duty_high;
    hsfm_pkg::temp_t       start_eff;
    logic signed [13:0]    temp_ext;
    logic signed [13:0]    rise;
    logic signed [13:0]    min_rise_ext;
    logic signed [13:0]    far_limit;
    logic                  no_rise;

    // Threshold times window length, rebuilt whenever no item resolves
    assign thr_recalc = {23'd0, cfg.duty_avg_threshold} * {11'd0, elapsed_reg};

    always_comb
    begin
        priority if (boiler_mv_reg < cfg.rail_low_mv)
            check_code = hsfm_pkg::FAULT_BOILER_OPEN;
        else if (boiler_mv_reg > cfg.rail_high_mv)
            check_code = hsfm_pkg::FAULT_BOILER_SHORT;
        else if (group_mv_reg < cfg.rail_low_mv)
            check_code = hsfm_pkg::FAULT_GROUP_OPEN;
        else if (group_mv_reg > cfg.rail_high_mv)
            check_code = hsfm_pkg::FAULT_GROUP_SHORT;
        else if (temp_reg > cfg.over_temp_limit)
            check_code = hsfm_pkg::FAULT_OVER_TEMP;
        else if (age_reg > cfg.stale_max_ms)
            check_code = hsfm_pkg::FAULT_STALE;
        else
            check_code = hsfm_pkg::FAULT_NONE;
    end

    assign elapsed_sum  = elapsed_reg + {7'd0, dt_reg};
    assign integral_sum = integral_reg + {7'd0, duty_prod_reg};
    assign thr_sum      = thr_time_reg + {7'd0, thr_prod_reg};
    assign window_close = elapsed_sum >= {1'b0, cfg.window_ms};
    // An empty window never counts as high duty
    assign duty_high    = (elapsed_sum != 23'd0) && (integral_sum >= thr_sum);

    assign start_eff    = started_reg ? start_temp_reg : temp_reg;
    assign temp_ext     = {temp_reg[12], temp_reg};
    assign rise         = temp_ext - {start_eff[12], start_eff};
    assign min_rise_ext = {cfg.min_rise[12], cfg.min_rise};
    assign far_limit    = {setpoint_reg[12], setpoint_reg}
                          - $signed({2'b00, cfg.setpoint_margin});
    assign no_rise      = duty_high && (rise < min_rise_ext) && (temp_ext < far_limit);

    always_comb
    begin
        latched_next    = latched_reg;
        started_next    = started_reg;
        elapsed_next    = elapsed_reg;
        integral_next   = integral_reg;
        thr_time_next   = thr_recalc;
        start_temp_next = start_temp_reg;
        fault_code_next = fault_code_reg;

        if (proc)
        begin
            thr_time_next = thr_time_reg;
            priority if (op_reg == hsfm_pkg::OP_CLEAR)
            begin
                latched_next    = hsfm_pkg::FAULT_NONE;
                started_next    = 1'b0;
                elapsed_next    = '0;
                integral_next   = '0;
                thr_time_next   = '0;
                start_temp_next = '0;
            end
            else if (latched_reg != hsfm_pkg::FAULT_NONE)
            begin
                // hold everything while a fault is latched
            end
            else if (check_code != hsfm_pkg::FAULT_NONE)
            begin
                latched_next = check_code;
            end
            else
            begin
                started_next = 1'b1;
                if (window_close)
                begin
                    if (no_rise)
                    begin
                        latched_next = hsfm_pkg::FAULT_NO_RISE;
                    end
                    elapsed_next    = '0;
                    integral_next   = '0;
                    thr_time_next   = '0;
                    start_temp_next = temp_reg;
                end
                else
                begin
                    elapsed_next    = elapsed_sum;
                    integral_next   = integral_sum;
                    thr_time_next   = thr_sum;
                    start_temp_next = start_eff;
                end
            end
            fault_code_next = latched_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg    <= hsfm_pkg::FAULT_NONE;
            started_reg    <= 1'b0;
            elapsed_reg    <= '0;
            integral_reg   <= '0;
            thr_time_reg   <= '0;
            start_temp_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            latched_reg    <= latched_next;
            started_reg    <= started_next;
            elapsed_reg    <= elapsed_next;
            integral_reg   <= integral_next;
            thr_time_reg   <= thr_time_next;
            start_temp_reg <= start_temp_next;
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fault_code_reg <= fault_code_next;
    end

    assign out_valid  = out_valid_reg;
    assign fault_code = fault_code_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_PROP(a_latch_holds, clk, rst_n,
        (latched_reg != hsfm_pkg::FAULT_NONE
            && !(proc && op_reg == hsfm_pkg::OP_CLEAR))
        |=> latched_reg == $past(latched_reg))

    `ASSERT_PROP(a_result_is_latch, clk, rst_n,
        proc |=> (out_valid && fault_code == latched_reg))

    `ASSERT_PROP(a_empty_window, clk, rst_n,
        elapsed_reg == 23'd0 |-> (integral_reg == 34'd0 && thr_time_reg == 34'd0))

    `ASSERT_PROP(a_latched_window_frozen, clk, rst_n,
        (proc && op_reg == hsfm_pkg::OP_SAMPLE && latched_reg != hsfm_pkg::FAULT_NONE)
        |=> ($stable(elapsed_reg) && $stable(integral_reg)))

endmodule

`default_nettype wire

### tb/sv/tb_heater_safety_fault_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heater_safety_fault_monitor
// Self-checking bench for the heater safety monitor. A queue-fed driver and a
// clocked monitor run random idles on all three channels. A behavioral model of the
// latched fault, the rail/overtemp/stale checks and the no-rise window
// predicts every fault code, and each returned code is compared in order.
// ----------------------------------------------------------------------------
module tb_heater_safety_fault_monitor;

    localparam int RESULT_LATENCY = 2;
    localparam int LAST_PHASE     = 9;

    typedef struct {
        logic            op;
        logic [11:0]     bmv;
        logic [11:0]     gmv;
        hsfm_pkg::temp_t temp;
        hsfm_pkg::temp_t setp;
        logic [15:0]     age;
        logic [15:0]     dt;
        logic [10:0]     duty;
    } heater_sample_t;

    typedef struct {
        logic [hsfm_pkg::CfgIndexWidth-1:0] idx;
        logic [hsfm_pkg::CfgDataWidth-1:0]  data;
    } reg_write_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_valid = 1'b0;
    logic in_valid  = 1'b0;
    logic out_ready = 1'b0;
    logic cfg_ready;
    logic in_ready;
    logic out_valid;
    logic [2:0] fault_code;

    heater_sample_t cur_sample = '{default: '0};
    reg_write_t     cur_write  = '{default: '0};

    heater_sample_t sample_queue[$];
    reg_write_t     write_queue[$];
    logic [2:0]     expected_faults[$];

    // handshakes seen at the last rising edge
    logic in_fire  = 1'b0;
    logic cfg_fire = 1'b0;

    int in_gap    = 0;
    int cfg_gap   = 0;
    int out_stall = 0;
    bit in_burst  = 1'b0;
    bit out_burst = 1'b0;

    int items_queued  = 0;
    int results_seen  = 0;
    int writes_queued = 0;
    int writes_done   = 0;
    int mismatches    = 0;
    int code_count[8] = '{default: 0};

    // settings the stimulus aims at, and the model's own copy of the registers
    hsfm_pkg::cfg_t plan;
    hsfm_pkg::cfg_t model_cfg;

    // model state
    logic [2:0]      latched;
    logic            win_open;
    logic [22:0]     win_ms_acc;
    logic [33:0]     duty_acc;
    hsfm_pkg::temp_t win_temp;

    int gen_temp = 0;

    heater_safety_fault_monitor u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cur_write.idx),
        .cfg_data        (cur_write.data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (cur_sample.op),
        .boiler_mv       (cur_sample.bmv),
        .group_mv        (cur_sample.gmv),
        .boiler_temp     (cur_sample.temp),
        .boiler_setpoint (cur_sample.setp),
        .reading_age_ms  (cur_sample.age),
        .elapsed_ms      (cur_sample.dt),
        .heater_duty     (cur_sample.duty),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .fault_code      (fault_code)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic hsfm_pkg::cfg_t reset_settings();
        return '{rail_low_mv:        hsfm_pkg::RST_RAIL_LOW,
                 rail_high_mv:       hsfm_pkg::RST_RAIL_HIGH,
                 over_temp_limit:    hsfm_pkg::RST_OVER_TEMP,
                 stale_max_ms:       hsfm_pkg::RST_STALE_MAX,
                 window_ms:          hsfm_pkg::RST_WINDOW,
                 duty_avg_threshold: hsfm_pkg::RST_DUTY_THRESH,
                 min_rise:           hsfm_pkg::RST_MIN_RISE,
                 setpoint_margin:    hsfm_pkg::RST_SP_MARGIN};
    endfunction

    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // value next to a boundary half the time, otherwise anywhere out to far_end
    function automatic int near_pick(input int adj, input int far_end);
        if ($urandom_range(0, 1) == 1)
            return adj;
        if (far_end >= adj)
            return adj + int'($urandom_range(0, far_end - adj));
        return adj - int'($urandom_range(0, adj - far_end));
    endfunction

    // ---------------------------------------------------------------- model

    function automatic void store_setting(input logic [hsfm_pkg::CfgIndexWidth-1:0] idx,
                                          input logic [hsfm_pkg::CfgDataWidth-1:0] data);
        case (idx)
            hsfm_pkg::REG_RAIL_LOW:    model_cfg.rail_low_mv        = data[11:0];
            hsfm_pkg::REG_RAIL_HIGH:   model_cfg.rail_high_mv       = data[11:0];
            hsfm_pkg::REG_OVER_TEMP:   model_cfg.over_temp_limit    = data[12:0];
            hsfm_pkg::REG_STALE_MAX:   model_cfg.stale_max_ms       = data[15:0];
            hsfm_pkg::REG_WINDOW:      model_cfg.window_ms          = data;
            hsfm_pkg::REG_DUTY_THRESH: model_cfg.duty_avg_threshold = data[10:0];
            hsfm_pkg::REG_MIN_RISE:    model_cfg.min_rise           = data[12:0];
            hsfm_pkg::REG_SP_MARGIN:   model_cfg.setpoint_margin    = data[11:0];
        endcase
    endfunction

    function automatic logic [2:0] predict_fault(input heater_sample_t s);
        logic duty_high;
        int   rise;
        int   floor_temp;
        if (s.op == hsfm_pkg::OP_CLEAR)
        begin
            latched    = hsfm_pkg::FAULT_NONE;
            win_open   = 1'b0;
            win_ms_acc = '0;
            duty_acc   = '0;
            win_temp   = '0;
            return hsfm_pkg::FAULT_NONE;
        end
        if (latched != hsfm_pkg::FAULT_NONE)
            return latched;

        if (s.bmv < model_cfg.rail_low_mv)
            latched = hsfm_pkg::FAULT_BOILER_OPEN;
        else if (s.bmv > model_cfg.rail_high_mv)
            latched = hsfm_pkg::FAULT_BOILER_SHORT;
        else if (s.gmv < model_cfg.rail_low_mv)
            latched = hsfm_pkg::FAULT_GROUP_OPEN;
        else if (s.gmv > model_cfg.rail_high_mv)
            latched = hsfm_pkg::FAULT_GROUP_SHORT;
        else if ($signed(s.temp) > $signed(model_cfg.over_temp_limit))
            latched = hsfm_pkg::FAULT_OVER_TEMP;
        else if (s.age > model_cfg.stale_max_ms)
            latched = hsfm_pkg::FAULT_STALE;
        if (latched != hsfm_pkg::FAULT_NONE)
            return latched;

        if (!win_open)
        begin
            win_open = 1'b1;
            win_temp = s.temp;
        end
        win_ms_acc = win_ms_acc + 23'(s.dt);
        duty_acc   = duty_acc + 34'(s.duty) * 34'(s.dt);

        if (win_ms_acc >= model_cfg.window_ms)
        begin
            // an empty window never counts as high duty
            duty_high  = (win_ms_acc != '0) &&
                         (64'(duty_acc) >= 64'(model_cfg.duty_avg_threshold) * 64'(win_ms_acc));
            rise       = int'($signed(s.temp)) - int'($signed(win_temp));
            floor_temp = int'($signed(s.setp)) - int'(model_cfg.setpoint_margin);
            if (duty_high && rise < int'($signed(model_cfg.min_rise)) &&
                int'($signed(s.temp)) < floor_temp)
                latched = hsfm_pkg::FAULT_NO_RISE;
            win_ms_acc = '0;
            duty_acc   = '0;
            win_temp   = s.temp;
        end
        return latched;
    endfunction

    // ------------------------------------------------------------ generators

    function automatic heater_sample_t random_sample();
        heater_sample_t s;
        s.op   = 1'($urandom);
        s.bmv  = 12'($urandom);
        s.gmv  = 12'($urandom);
        s.temp = 13'($urandom);
        s.setp = 13'($urandom);
        s.age  = 16'($urandom);
        s.dt   = 16'($urandom);
        s.duty = 11'($urandom);
        return s;
    endfunction

    function automatic heater_sample_t clear_sample();
        heater_sample_t s;
        s    = random_sample();
        s.op = hsfm_pkg::OP_CLEAR;
        return s;
    endfunction

    function automatic logic [11:0] pick_rail();
        if (plan.rail_low_mv <= plan.rail_high_mv)
            return plan.rail_low_mv +
                   12'($urandom_range(0, plan.rail_high_mv - plan.rail_low_mv));
        return 12'($urandom);
    endfunction

    // passes the rail, overtemp and stale checks under the planned settings, where any such sample exists
    function automatic heater_sample_t healthy_sample();
        heater_sample_t s;
        int lo;
        int hi;
        int r;
        lo = -800;
        hi = clamp_int(int'($signed(plan.over_temp_limit)), -4096, 4000);
        if (hi < lo)
            lo = hi;
        if ($urandom_range(0, 19) == 0)
            gen_temp = lo + int'($urandom_range(0, hi - lo));
        else
            gen_temp = gen_temp + int'($urandom_range(0, 12)) - 5;
        gen_temp = clamp_int(gen_temp, lo, hi);

        s.op   = hsfm_pkg::OP_SAMPLE;
        s.bmv  = pick_rail();
        s.gmv  = pick_rail();
        s.temp = hsfm_pkg::temp_t'(gen_temp);
        s.setp = hsfm_pkg::temp_t'(clamp_int(gen_temp + int'($urandom_range(0, 1500)) - 300,
                                             -4096, 4095));
        s.age  = 16'($urandom_range(0, plan.stale_max_ms));
        r = $urandom_range(0, 99);
        if (r < 70)
            s.dt = 16'($urandom_range(0, 300));
        else if (r < 95)
            s.dt = 16'($urandom_range(0, 3000));
        else
            s.dt = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 60)
            s.duty = 11'($urandom_range(850, 1024));
        else if (r < 95)
            s.duty = 11'($urandom_range(0, 1024));
        else
            s.duty = 11'($urandom);
        return s;
    endfunction

    // push one field past its limit; kinds follow the check priority
    function automatic heater_sample_t with_fault(input heater_sample_t s, input int kind);
        int lim;
        case (kind)
            0: if (plan.rail_low_mv != 0)
                   s.bmv = 12'(near_pick(int'(plan.rail_low_mv) - 1, 0));
            1: if (plan.rail_high_mv != 12'hFFF)
                   s.bmv = 12'(near_pick(int'(plan.rail_high_mv) + 1, 4095));
            2: if (plan.rail_low_mv != 0)
                   s.gmv = 12'(near_pick(int'(plan.rail_low_mv) - 1, 0));
            3: if (plan.rail_high_mv != 12'hFFF)
                   s.gmv = 12'(near_pick(int'(plan.rail_high_mv) + 1, 4095));
            4:
            begin
                lim = int'($signed(plan.over_temp_limit));
                if (lim < 4095)
                    s.temp = hsfm_pkg::temp_t'(near_pick(lim + 1,
                                                         clamp_int(lim + 400, -4096, 4095)));
            end
            default: if (plan.stale_max_ms != 16'hFFFF)
                   s.age = 16'(near_pick(int'(plan.stale_max_ms) + 1, 65535));
        endcase
        return s;
    endfunction

    function automatic hsfm_pkg::cfg_t phase_settings(input int phase);
        hsfm_pkg::cfg_t c;
        case (phase)
            // wide-open limits, zero-length window
            1: c = '{rail_low_mv: 12'd0, rail_high_mv: 12'd4095,
                     over_temp_limit: 13'sd4000, stale_max_ms: 16'd65535,
                     window_ms: 22'd0, duty_avg_threshold: 11'd0,
                     min_rise: 13'sd4000, setpoint_margin: 12'd0};
            // tightest rail and stale limits, a long window
            2: c = '{rail_low_mv: 12'd4095, rail_high_mv: 12'd0,
                     over_temp_limit: -13'sd800, stale_max_ms: 16'd0,
                     window_ms: 22'd3600000, duty_avg_threshold: 11'd1024,
                     min_rise: -13'sd800, setpoint_margin: 12'd4000};
            // full register widths past the nominal ranges
            3: c = '{rail_low_mv: 12'd300, rail_high_mv: 12'd3000,
                     over_temp_limit: 13'sd4095, stale_max_ms: 16'd30000,
                     window_ms: 22'd1, duty_avg_threshold: 11'd2047,
                     min_rise: 13'sd4095, setpoint_margin: 12'd4095};
            default:
            begin
                c.rail_low_mv        = 12'($urandom_range(0, 400));
                c.rail_high_mv       = 12'($urandom_range(2800, 4095));
                c.over_temp_limit    = hsfm_pkg::temp_t'($urandom_range(1000, 4000));
                c.stale_max_ms       = 16'($urandom_range(500, 65535));
                c.window_ms          = ($urandom_range(0, 9) == 0) ? 22'($urandom) :
                                       22'($urandom_range(0, 2500));
                c.duty_avg_threshold = 11'($urandom_range(500, 1024));
                c.min_rise           = hsfm_pkg::temp_t'(int'($urandom_range(0, 300)) - 100);
                c.setpoint_margin    = 12'($urandom_range(0, 600));
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------ stimulus

    task automatic queue_sample(input heater_sample_t s);
        sample_queue.push_back(s);
        items_queued++;
    endtask

    task automatic wait_results();
        while (results_seen < items_queued)
            @(negedge clk);
        repeat (2 * RESULT_LATENCY) @(negedge clk);
    endtask

    task automatic write_settings(input hsfm_pkg::cfg_t c);
        reg_write_t w;
        for (int i = 0; i < 8; i++)
        begin
            w.idx  = hsfm_pkg::CfgIndexWidth'(i);
            // bits above a register's width carry junk
            w.data = hsfm_pkg::CfgDataWidth'($urandom);
            case (w.idx)
                hsfm_pkg::REG_RAIL_LOW:    w.data[11:0] = c.rail_low_mv;
                hsfm_pkg::REG_RAIL_HIGH:   w.data[11:0] = c.rail_high_mv;
                hsfm_pkg::REG_OVER_TEMP:   w.data[12:0] = c.over_temp_limit;
                hsfm_pkg::REG_STALE_MAX:   w.data[15:0] = c.stale_max_ms;
                hsfm_pkg::REG_WINDOW:      w.data       = c.window_ms;
                hsfm_pkg::REG_DUTY_THRESH: w.data[10:0] = c.duty_avg_threshold;
                hsfm_pkg::REG_MIN_RISE:    w.data[12:0] = c.min_rise;
                hsfm_pkg::REG_SP_MARGIN:   w.data[11:0] = c.setpoint_margin;
            endcase
            write_queue.push_back(w);
            writes_queued++;
        end
        while (writes_done < writes_queued)
            @(negedge clk);
    endtask

    task automatic queue_random_samples(input int count);
        heater_sample_t s;
        int r;
        for (int i = 0; i < count; i++)
        begin
            // halfway through, hold off until the block has drained
            if (i == count / 2)
                wait_results();
            r = $urandom_range(0, 99);
            if (r < 6)
                s = clear_sample();
            else if (r < 12)
                s = random_sample();
            else
            begin
                s = healthy_sample();
                if (r < 22)
                    s = with_fault(s, $urandom_range(0, 5));
            end
            queue_sample(s);
        end
    endtask

    initial
    begin
        heater_sample_t s;
        int count;
        plan = reset_settings();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // boundary values do not trip
        s = healthy_sample();
        s.bmv  = hsfm_pkg::RST_RAIL_LOW;
        s.gmv  = hsfm_pkg::RST_RAIL_HIGH;
        s.temp = hsfm_pkg::RST_OVER_TEMP;
        s.age  = hsfm_pkg::RST_STALE_MAX;
        s.dt   = '0;
        s.duty = '0;
        queue_sample(s);

        for (int k = 0; k < 6; k++)
        begin
            s = healthy_sample();
            s.dt = 16'd10;
            queue_sample(with_fault(s, k));
            // latched code repeats on the next sample
            if (k == 0)
                queue_sample(healthy_sample());
            queue_sample(clear_sample());
        end

        // boiler open, group short, overtemp and stale fire at once: the boiler open code wins
        s = healthy_sample();
        s.bmv  = '0;
        s.gmv  = 12'hFFF;
        s.temp = 13'sd4000;
        s.age  = 16'hFFFF;
        queue_sample(s);
        queue_sample(clear_sample());

        // one sample fills the window at full duty, far below setpoint
        s = healthy_sample();
        s.temp = 13'sd0;
        s.setp = 13'sd1000;
        s.dt   = 16'd60000;
        s.duty = 11'd1024;
        queue_sample(s);
        queue_sample(clear_sample());

        // window closes with no heat, then with full heat at the extremes
        s = healthy_sample();
        s.bmv  = 12'd2048;
        s.gmv  = 12'd2047;
        s.temp = -13'sd800;
        s.setp = 13'sd4000;
        s.age  = '0;
        s.dt   = 16'hFFFF;
        s.duty = '0;
        queue_sample(s);
        s.duty = 11'd1024;
        queue_sample(s);
        queue_sample(clear_sample());
        wait_results();

        for (int phase = 1; phase <= LAST_PHASE; phase++)
        begin
            plan = phase_settings(phase);
            write_settings(plan);
            case (phase)
                1: count = 150;
                2: count = 60;
                3: count = 120;
                default: count = 200;
            endcase
            queue_random_samples(count);
            wait_results();
        end

        if (expected_faults.size() != 0)
        begin
            $error("%0d fault codes never arrived", expected_faults.size());
            mismatches++;
        end
        $display("Checked %0d fault codes from %0d items over %0d register settings",
                 results_seen, items_queued, LAST_PHASE + 1);
        $display("Codes seen: none %0d, rail %0d, overtemp %0d, no-rise %0d, stale %0d",
                 code_count[hsfm_pkg::FAULT_NONE],
                 code_count[hsfm_pkg::FAULT_BOILER_OPEN] +
                 code_count[hsfm_pkg::FAULT_BOILER_SHORT] +
                 code_count[hsfm_pkg::FAULT_GROUP_OPEN] +
                 code_count[hsfm_pkg::FAULT_GROUP_SHORT],
                 code_count[hsfm_pkg::FAULT_OVER_TEMP], code_count[hsfm_pkg::FAULT_NO_RISE],
                 code_count[hsfm_pkg::FAULT_STALE]);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------ drivers

    always @(negedge clk)
    begin
        if (!in_valid || in_fire)
        begin
            if ($urandom_range(0, 99) == 0)
                in_burst <= !in_burst;
            if (in_gap != 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (sample_queue.size() != 0)
            begin
                cur_sample <= sample_queue.pop_front();
                in_valid   <= 1'b1;
                in_gap     <= pick_gap(in_burst);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!cfg_valid || cfg_fire)
        begin
            if (cfg_gap != 0)
            begin
                cfg_valid <= 1'b0;
                cfg_gap   <= cfg_gap - 1;
            end
            else if (write_queue.size() != 0)
            begin
                cur_write <= write_queue.pop_front();
                cfg_valid <= 1'b1;
                cfg_gap   <= pick_gap(1'b0);
            end
            else
            begin
                cfg_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if ($urandom_range(0, 99) == 0)
            out_burst <= !out_burst;
        if (out_stall != 0)
        begin
            out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            out_stall <= pick_gap(out_burst);
        end
    end

    // ------------------------------------------------------------ monitor

    always @(posedge clk)
    begin
        logic [2:0] want;
        if (!rst_n)
        begin
            model_cfg  = reset_settings();
            latched    = hsfm_pkg::FAULT_NONE;
            win_open   = 1'b0;
            win_ms_acc = '0;
            duty_acc   = '0;
            win_temp   = '0;
            in_fire    <= 1'b0;
            cfg_fire   <= 1'b0;
        end
        else
        begin
            in_fire  <= in_valid && in_ready;
            cfg_fire <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready)
            begin
                store_setting(cur_write.idx, cur_write.data);
                writes_done++;
            end
            // check the returning code before queueing the new item's code
            if (out_valid && out_ready)
            begin
                if (expected_faults.size() == 0)
                begin
                    $error("fault_code %0d arrived with nothing expected", fault_code);
                    mismatches++;
                end
                else
                begin
                    want = expected_faults.pop_front();
                    if (fault_code !== want)
                    begin
                        $error("fault_code mismatch: expected %0d, got %0d", want, fault_code);
                        mismatches++;
                    end
                end
                code_count[fault_code]++;
                results_seen++;
            end
            if (in_valid && in_ready)
                expected_faults.push_back(predict_fault(cur_sample));
        end
    end

endmodule
